FILE: rtl/cgs_pkg.sv
`timescale 1ns / 1ps

package cgs_pkg;

  // Grayscale depth: pages per scan cycle, the last page of a cycle is the off page.
  localparam int SHADE_LEVELS = 8;
  localparam int PAGES        = SHADE_LEVELS - 1;
  localparam int PAGE_W       = $clog2(SHADE_LEVELS);

  // LED map size and the highest LED number a write may address.
  localparam int LED_COUNT = 42;
  localparam int MAP_SIZE  = 42;
  localparam int IDX_MAX   = (LED_COUNT < MAP_SIZE) ? LED_COUNT - 1 : MAP_SIZE - 1;
  localparam int IDX_W     = $clog2(MAP_SIZE);

  // Widths of the scan cycle counter and of the pin word.
  localparam int CYC_W = 4;
  localparam int PIN_W = 16;

  // Command codes of one request.
  typedef enum logic [1:0] {
    CMD_SET_PIXEL    = 2'd0,
    CMD_SCAN_TICK    = 2'd1,
    CMD_REQUEST_FLIP = 2'd2
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_GRAYSCALE  = 1'b0,
    REG_DOUBLE_BUF = 1'b1
  } cfg_reg_t;

  // Source line and scan cycle of one LED.
  typedef struct packed {
    logic [3:0]       src;
    logic [CYC_W-1:0] cyc;
  } led_pos_t;

  // Frame store port controls.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // Source line of each LED.
  localparam logic [3:0] LED_SRC_ROM [MAP_SIZE] = '{
    4'd5,  4'd5,  4'd5,  4'd5,  4'd5,  4'd5,
    4'd6,  4'd6,  4'd6,  4'd6,  4'd6,  4'd6,
    4'd7,  4'd7,  4'd7,  4'd7,  4'd7,  4'd7,
    4'd8,  4'd8,  4'd8,  4'd8,  4'd8,  4'd8,
    4'd2,  4'd2,  4'd2,  4'd2,  4'd2,  4'd2,
    4'd12, 4'd12, 4'd12, 4'd4,  4'd4,  4'd4,
    4'd4,  4'd4,  4'd4,  4'd12, 4'd12, 4'd12
  };

  // Scan cycle of each LED.
  localparam logic [CYC_W-1:0] LED_CYC_ROM [MAP_SIZE] = '{
    4'd10, 4'd0,  4'd2,  4'd4,  4'd5,  4'd6,
    4'd0,  4'd10, 4'd2,  4'd3,  4'd5,  4'd6,
    4'd0,  4'd10, 4'd2,  4'd3,  4'd4,  4'd6,
    4'd0,  4'd2,  4'd4,  4'd5,  4'd3,  4'd10,
    4'd10, 4'd2,  4'd3,  4'd4,  4'd5,  4'd6,
    4'd0,  4'd2,  4'd3,  4'd6,  4'd5,  4'd4,
    4'd3,  4'd10, 4'd0,  4'd6,  4'd5,  4'd4
  };

  // Looks up the position of one LED; numbers past the map give zero.
  function automatic led_pos_t led_lookup(input logic [IDX_W-1:0] idx);
    led_pos_t pos;
    pos = '0;
    if (32'(idx) < MAP_SIZE) begin
      pos.src = LED_SRC_ROM[idx];
      pos.cyc = LED_CYC_ROM[idx];
    end
    return pos;
  endfunction

endpackage

FILE: rtl/cgs_ram.sv
`timescale 1ns / 1ps

module cgs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 168,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/cgs_pixel_wr.sv
`timescale 1ns / 1ps

module cgs_pixel_wr #(
  parameter int SCAN_CYCLES = 12,
  parameter int AW          = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   go,
  input  logic [7:0]             led_index,
  input  logic [7:0]             shade,
  input  logic                   grayscale_en,
  input  logic                   buf_sel,
  output logic                   busy,
  output cgs_pkg::mem_ctl_t      mem_ctl,
  output logic [AW-1:0]          raddr,
  output logic [AW-1:0]          waddr,
  output logic [cgs_pkg::PIN_W-1:0] wdata,
  input  logic [cgs_pkg::PIN_W-1:0] rdata
);

  import cgs_pkg::*;

  logic [IDX_W-1:0]  idx_clamped;
  led_pos_t          pos;
  logic [PAGE_W-1:0] level;
  logic              cyc_ok;
  logic [AW-1:0]     base;

  logic              active_r, active_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic [PAGE_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic [PAGE_W-1:0] wr_cnt_r, wr_cnt_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic [PIN_W-1:0]  mask_r, mask_nxt;
  logic [PAGE_W-1:0] level_r, level_nxt;

  // Clamp the LED number and shade, then find the LED's words in the work buffer.
  always_comb begin
    if (led_index > 8'(IDX_MAX)) begin
      idx_clamped = IDX_W'(IDX_MAX);
    end else begin
      idx_clamped = led_index[IDX_W-1:0];
    end
    pos = led_lookup(idx_clamped);

    if (shade == 8'd0) begin
      level = '0;
    end else if (!grayscale_en || shade > 8'(PAGES)) begin
      level = PAGE_W'(PAGES);
    end else begin
      level = shade[PAGE_W-1:0];
    end

    cyc_ok = 32'(pos.cyc) < SCAN_CYCLES;
    base   = (buf_sel ? AW'(SCAN_CYCLES * PAGES) : '0) + AW'(pos.cyc) * AW'(PAGES);
  end

  // Read one page word per cycle; each is modified and written back in the following cycle.
  always_comb begin
    active_nxt  = active_r;
    wr_pend_nxt = active_r;
    rd_cnt_nxt  = rd_cnt_r;
    wr_cnt_nxt  = rd_cnt_r;
    base_nxt    = base_r;
    mask_nxt    = mask_r;
    level_nxt   = level_r;

    if (go) begin
      active_nxt = cyc_ok;
      rd_cnt_nxt = '0;
      base_nxt   = base;
      mask_nxt   = PIN_W'(1) << pos.src;
      level_nxt  = level;
    end else if (active_r) begin
      if (rd_cnt_r == PAGE_W'(PAGES - 1)) begin
        active_nxt = 1'b0;
      end else begin
        rd_cnt_nxt = rd_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      wr_pend_r <= 1'b0;
      rd_cnt_r  <= '0;
      wr_cnt_r  <= '0;
    end else begin
      active_r  <= active_nxt;
      wr_pend_r <= wr_pend_nxt;
      rd_cnt_r  <= rd_cnt_nxt;
      wr_cnt_r  <= wr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r  <= base_nxt;
    mask_r  <= mask_nxt;
    level_r <= level_nxt;
  end

  // The source bit is lit in the first pages up to the shade and dark in the rest.
  assign mem_ctl.rd_en = active_r;
  assign mem_ctl.wr_en = wr_pend_r;
  assign raddr         = base_r + AW'(rd_cnt_r);
  assign waddr         = base_r + AW'(wr_cnt_r);
  assign wdata         = (wr_cnt_r < level_r) ? (rdata | mask_r) : (rdata & ~mask_r);
  assign busy          = active_r | wr_pend_r;

endmodule

FILE: rtl/cgs_scan.sv
`timescale 1ns / 1ps

module cgs_scan #(
  parameter int SCAN_CYCLES = 12,
  parameter int AW          = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic                       flip_set,
  input  logic                       double_buf_en,
  output logic                       busy,
  output logic                       display_sel,
  output logic                       rd_en,
  output logic [AW-1:0]              raddr,
  input  logic [cgs_pkg::PIN_W-1:0]  rdata,
  output logic                       out_valid,
  output logic [cgs_pkg::PIN_W-1:0]  out_driven_pins,
  output logic [cgs_pkg::CYC_W-1:0]  out_sink_line,
  output logic [cgs_pkg::PAGE_W-1:0] out_page_index,
  output logic                       out_frame_end,
  output logic                       out_buffers_swapped
);

  import cgs_pkg::*;

  logic [CYC_W-1:0]  cyc_r, cyc_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic              dsel_r, dsel_nxt;
  logic              flip_r, flip_nxt;
  logic              pend_r;
  logic              off_r;
  logic              off_page;
  logic [CYC_W-1:0]  sink;
  logic              last_page, last_cyc, frame_end, swapped;

  logic              out_valid_r;
  logic [PIN_W-1:0]  pins_r;
  logic [CYC_W-1:0]  sink_r;
  logic [PAGE_W-1:0] page_out_r;
  logic              frame_end_r, swapped_r;

  // Fetch the page word of the displayed buffer; the off page needs no read.
  assign off_page = page_r == PAGE_W'(PAGES);
  assign rd_en    = go & ~off_page;
  assign raddr    = (dsel_r ? AW'(SCAN_CYCLES * PAGES) : '0)
                  + AW'(cyc_r) * AW'(PAGES) + AW'(page_r);

  // Page and cycle advance, with a pending flip taken at frame end.
  always_comb begin
    sink      = cyc_r + CYC_W'(2);
    last_page = page_r == PAGE_W'(SHADE_LEVELS - 1);
    last_cyc  = cyc_r == CYC_W'(SCAN_CYCLES - 1);
    frame_end = last_page & last_cyc;
    swapped   = frame_end & flip_r;

    cyc_nxt  = cyc_r;
    page_nxt = page_r;
    dsel_nxt = dsel_r;
    flip_nxt = flip_r | flip_set;
    if (pend_r) begin
      if (last_page) begin
        page_nxt = '0;
        cyc_nxt  = last_cyc ? '0 : cyc_r + 1'b1;
      end else begin
        page_nxt = page_r + 1'b1;
      end
      if (swapped) begin
        flip_nxt = 1'b0;
        dsel_nxt = dsel_r ^ double_buf_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cyc_r       <= '0;
      page_r      <= '0;
      dsel_r      <= 1'b0;
      flip_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cyc_r       <= cyc_nxt;
      page_r      <= page_nxt;
      dsel_r      <= dsel_nxt;
      flip_r      <= flip_nxt;
      pend_r      <= go;
      out_valid_r <= pend_r;
    end
  end

  // Result register: loaded when the page word returns.
  always_ff @(posedge clk) begin
    if (go) begin
      off_r <= off_page;
    end
    if (pend_r) begin
      pins_r      <= (PIN_W'(1) << sink) | (off_r ? '0 : rdata);
      sink_r      <= sink;
      page_out_r  <= page_r;
      frame_end_r <= frame_end;
      swapped_r   <= swapped;
    end
  end

  assign busy                = pend_r;
  assign display_sel         = dsel_r;
  assign out_valid           = out_valid_r;
  assign out_driven_pins     = pins_r;
  assign out_sink_line       = sink_r;
  assign out_page_index      = page_out_r;
  assign out_frame_end       = frame_end_r;
  assign out_buffers_swapped = swapped_r;

endmodule

FILE: rtl/charlieplex_grayscale_scan_unit.sv
`timescale 1ns / 1ps

// Charlieplexed 42-LED scan unit with bit-plane grayscale. A request is taken
// when start is high and busy is low. set_pixel keeps the unit busy while the
// seven page words of the LED's scan cycle go through a read-modify-write over
// the single read and single write port of the frame store. scan_tick keeps it
// busy for one frame store read; its result passes the registered read port and
// the result register to the out_ ports, marked by out_valid for exactly one
// cycle; the receiver cannot stall it. request_flip and the unused command do
// not make the unit busy. The frame store powers up dark through per-word valid
// flags, so no clearing pass runs after reset. Configuration writes are always
// ready.

module charlieplex_grayscale_scan_unit #(
  parameter int SCAN_CYCLES = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_led_index,
  input  logic [7:0]  in_shade,
  output logic        out_valid,
  output logic [15:0] out_driven_pins,
  output logic [3:0]  out_sink_line,
  output logic [2:0]  out_page_index,
  output logic        out_frame_end,
  output logic        out_buffers_swapped,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic        cfg_wdata
);

  import cgs_pkg::*;

  localparam int DEPTH = 2 * SCAN_CYCLES * PAGES;
  localparam int AW    = $clog2(DEPTH);

  logic             grayscale_r, double_buf_r;
  logic             accept;
  logic             wr_go, sc_go, flip_set;
  logic             wr_busy, sc_busy;
  logic             display_sel;
  mem_ctl_t         wr_ctl, mem_ctl;
  logic             sc_rd_en;
  logic [AW-1:0]    wr_raddr, sc_raddr, raddr, waddr;
  logic [PIN_W-1:0] wdata, ram_q, rdata;
  logic             vld_r [DEPTH];
  logic             rd_vld_r;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grayscale_r  <= 1'b0;
      double_buf_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GRAYSCALE:  grayscale_r  <= cfg_wdata;
        REG_DOUBLE_BUF: double_buf_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Command decode.
  assign busy   = wr_busy | sc_busy;
  assign accept = start & ~busy;

  always_comb begin
    wr_go    = 1'b0;
    sc_go    = 1'b0;
    flip_set = 1'b0;
    if (accept) begin
      unique case (cmd_t'(in_command))
        CMD_SET_PIXEL:    wr_go    = 1'b1;
        CMD_SCAN_TICK:    sc_go    = 1'b1;
        CMD_REQUEST_FLIP: flip_set = 1'b1;
        default: ;
      endcase
    end
  end

  cgs_pixel_wr #(
    .SCAN_CYCLES (SCAN_CYCLES),
    .AW          (AW)
  ) u_pixel_wr (
    .clk          (clk),
    .rst_n        (rst_n),
    .go           (wr_go),
    .led_index    (in_led_index),
    .shade        (in_shade),
    .grayscale_en (grayscale_r),
    .buf_sel      (display_sel ^ double_buf_r),
    .busy         (wr_busy),
    .mem_ctl      (wr_ctl),
    .raddr        (wr_raddr),
    .waddr        (waddr),
    .wdata        (wdata),
    .rdata        (rdata)
  );

  cgs_scan #(
    .SCAN_CYCLES (SCAN_CYCLES),
    .AW          (AW)
  ) u_scan (
    .clk                 (clk),
    .rst_n               (rst_n),
    .go                  (sc_go),
    .flip_set            (flip_set),
    .double_buf_en       (double_buf_r),
    .busy                (sc_busy),
    .display_sel         (display_sel),
    .rd_en               (sc_rd_en),
    .raddr               (sc_raddr),
    .rdata               (rdata),
    .out_valid           (out_valid),
    .out_driven_pins     (out_driven_pins),
    .out_sink_line       (out_sink_line),
    .out_page_index      (out_page_index),
    .out_frame_end       (out_frame_end),
    .out_buffers_swapped (out_buffers_swapped)
  );

  // Frame store port sharing: the writer and the scan never run together.
  assign mem_ctl.rd_en = wr_ctl.rd_en | sc_rd_en;
  assign mem_ctl.wr_en = wr_ctl.wr_en;
  assign raddr         = wr_ctl.rd_en ? wr_raddr : sc_raddr;

  cgs_ram #(
    .WIDTH (PIN_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (mem_ctl.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .re    (mem_ctl.rd_en),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // A word never written since reset reads as dark.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '{default: 1'b0};
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_ctl.wr_en) begin
        vld_r[waddr] <= 1'b1;
      end
      if (mem_ctl.rd_en) begin
        rd_vld_r <= vld_r[raddr];
      end
    end
  end

  assign rdata = rd_vld_r ? ram_q : '0;

  // The pixel writer and the scan never hold the frame store at the same time.
  a_one_user: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_busy && sc_busy))
    else $error("pixel writer and scan active together");

  // A write-back never targets the word being read in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_ctl.rd_en && mem_ctl.wr_en) |-> (raddr != waddr))
    else $error("frame store read and write hit the same word");

  // Every result follows a scan fetch cycle.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(sc_busy))
    else $error("result without a scan fetch");

  // The sink line stays within the scanned lines.
  a_sink_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sink_line >= 4'd2 && 32'(out_sink_line) <= SCAN_CYCLES + 1))
    else $error("sink line out of range");

endmodule

FILE: tb/charlieplex_grayscale_scan_unit_tb.sv
`timescale 1ns / 1ps

module charlieplex_grayscale_scan_unit_tb;
  import cgs_pkg::*;

  localparam int SCAN_CYCLES = 12;
  localparam int STORE_WORDS = SCAN_CYCLES * PAGES;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SEGMENTS = 6;
  localparam int SEGMENT_ITEMS = 230;
  // Register settings of each random segment, one bit per segment.
  localparam logic [SEGMENTS-1:0] GRAY_PLAN = 6'b010110;
  localparam logic [SEGMENTS-1:0] DBUF_PLAN = 6'b011100;

  // One emitted scan page as seen on the result ports.
  typedef struct {
    logic [15:0] pins;
    logic [3:0]  sink;
    logic [2:0]  page;
    logic        frame_end;
    logic        swapped;
  } scan_page_t;

  // Tracks the display state and holds the scan pages still to come out.
  class scan_scoreboard;
    bit          gray_en;
    bit          dbuf_en;
    logic [15:0] page_word [2][STORE_WORDS];
    int unsigned scan_cycle;
    int unsigned scan_page;
    bit          display_sel;
    bit          flip_pending;
    scan_page_t  due_pages [$];
    int          errors;

    function new();
      for (int b = 0; b < 2; b++)
        for (int w = 0; w < STORE_WORDS; w++)
          page_word[b][w] = '0;
      gray_en = 0;
      dbuf_en = 0;
      scan_cycle = 0;
      scan_page = 0;
      display_sel = 0;
      flip_pending = 0;
      errors = 0;
    endfunction

    function void set_register(cfg_reg_t idx, bit val);
      if (idx == REG_GRAYSCALE) gray_en = val;
      else dbuf_en = val;
    endfunction

    function int pending();
      return due_pages.size();
    endfunction

    // Writes one LED's shade into the page words of its scan cycle.
    function void paint_led(logic [7:0] idx, logic [7:0] shade);
      int unsigned led, lvl, buf_sel, base;
      logic [15:0] mask;
      led = (idx > IDX_MAX) ? IDX_MAX : idx;
      lvl = shade;
      if (lvl > 0 && !gray_en) lvl = PAGES;
      if (lvl > PAGES) lvl = PAGES;
      if (LED_CYC_ROM[led] >= SCAN_CYCLES) return;
      mask = 16'(1) << LED_SRC_ROM[led];
      buf_sel = display_sel ^ dbuf_en;
      base = LED_CYC_ROM[led] * PAGES;
      for (int p = 0; p < PAGES; p++) begin
        if (p < lvl) page_word[buf_sel][base + p] |= mask;
        else page_word[buf_sel][base + p] &= ~mask;
      end
    endfunction

    // Emits the current page and steps the scan, swapping buffers at frame end.
    function void step_scan();
      scan_page_t res;
      int unsigned cyc, pg;
      cyc = (scan_cycle >= SCAN_CYCLES) ? 0 : scan_cycle;
      pg = scan_page;
      res.pins = 16'(1) << ((cyc + 2) & 15);
      if (pg < PAGES) res.pins |= page_word[display_sel][cyc * PAGES + pg];
      res.sink = 4'(cyc + 2);
      res.page = 3'(pg);
      res.frame_end = 0;
      res.swapped = 0;
      pg++;
      if (pg >= SHADE_LEVELS) begin
        pg = 0;
        cyc++;
        if (cyc >= SCAN_CYCLES) begin
          cyc = 0;
          res.frame_end = 1;
          if (flip_pending) begin
            flip_pending = 0;
            res.swapped = 1;
            if (dbuf_en) display_sel = ~display_sel;
          end
        end
      end
      scan_page = pg;
      scan_cycle = cyc;
      due_pages.push_back(res);
    endfunction

    // Called for every accepted request.
    function void note_request(logic [1:0] cmd, logic [7:0] idx, logic [7:0] shade);
      case (cmd)
        CMD_SET_PIXEL:    paint_led(idx, shade);
        CMD_SCAN_TICK:    step_scan();
        CMD_REQUEST_FLIP: flip_pending = 1;
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
    endfunction

    // Compares one scan page with the oldest one due.
    function void check_result(scan_page_t got);
      scan_page_t want;
      if (due_pages.size() == 0) begin
        errors++;
        $display("%0t: scan page with none due, pins %h", $time, got.pins);
        return;
      end
      want = due_pages.pop_front();
      compare_field("driven_pins", want.pins, got.pins);
      compare_field("sink_line", 16'(want.sink), 16'(got.sink));
      compare_field("page_index", 16'(want.page), 16'(got.page));
      compare_field("frame_end", 16'(want.frame_end), 16'(got.frame_end));
      compare_field("buffers_swapped", 16'(want.swapped), 16'(got.swapped));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = CMD_SET_PIXEL;
  logic [7:0]  in_led_index = '0;
  logic [7:0]  in_shade = '0;
  logic        out_valid;
  logic [15:0] out_driven_pins;
  logic [3:0]  out_sink_line;
  logic [2:0]  out_page_index;
  logic        out_frame_end;
  logic        out_buffers_swapped;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_GRAYSCALE;
  logic        cfg_wdata = 1'b0;

  scan_scoreboard sb = new();

  charlieplex_grayscale_scan_unit #(
    .SCAN_CYCLES(SCAN_CYCLES)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_command(in_command),
    .in_led_index(in_led_index),
    .in_shade(in_shade),
    .out_valid(out_valid),
    .out_driven_pins(out_driven_pins),
    .out_sink_line(out_sink_line),
    .out_page_index(out_page_index),
    .out_frame_end(out_frame_end),
    .out_buffers_swapped(out_buffers_swapped),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Scan pages are taken at the edge that ends their one valid cycle.
  always @(posedge clk) begin
    scan_page_t got;
    if (rst_n && out_valid) begin
      got.pins = out_driven_pins;
      got.sink = out_sink_line;
      got.page = out_page_index;
      got.frame_end = out_frame_end;
      got.swapped = out_buffers_swapped;
      sb.check_result(got);
    end
  end

  // Drives one request, optionally after an idle gap, and waits until it is taken.
  task automatic issue_request(logic [1:0] cmd, logic [7:0] idx, logic [7:0] shade,
                               int idle_pct);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_led_index <= idx;
    in_shade <= shade;
    do @(posedge clk); while (busy);
    sb.note_request(cmd, idx, shade);
  endtask

  // Writes one register and returns in the cycle after the write.
  task automatic write_register(cfg_reg_t idx, bit val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until all scan pages are out and a pixel write has surely finished.
  task automatic settle();
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (12) @(posedge clk);
  endtask

  // Draws one random request; most are pixel writes and scan ticks.
  task automatic random_request(int flip_pct, int idle_pct);
    logic [1:0] cmd;
    logic [7:0] idx, shade;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35) cmd = CMD_SET_PIXEL;
    else if (pick < 35 + flip_pct) cmd = CMD_REQUEST_FLIP;
    else if (pick < 38 + flip_pct) cmd = CMD_UNUSED;
    else cmd = CMD_SCAN_TICK;
    pick = $urandom_range(99);
    idx = (pick < 70) ? 8'($urandom_range(IDX_MAX)) : 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 50) shade = 8'($urandom_range(PAGES));
    else if (pick < 70) shade = 8'($urandom_range(15));
    else shade = 8'($urandom_range(255));
    issue_request(cmd, idx, shade, idle_pct);
  endtask

  // Run limit.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int idle_pct;
    int flip_pct;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: clamping of index and shade, the unused command, merged flips in
    // single-buffer mode, and the first two scan cycles including their off pages.
    write_register(REG_GRAYSCALE, 1'b1);
    issue_request(CMD_SET_PIXEL, 8'd1, 8'd9, 0);
    issue_request(CMD_SET_PIXEL, 8'd6, 8'd0, 0);
    issue_request(CMD_SET_PIXEL, 8'd255, 8'd255, 0);
    issue_request(CMD_SET_PIXEL, 8'd42, 8'd3, 0);
    issue_request(CMD_SET_PIXEL, 8'd0, 8'd7, 0);
    issue_request(CMD_SET_PIXEL, 8'd12, 8'd8, 0);
    issue_request(CMD_UNUSED, 8'd255, 8'd255, 0);
    issue_request(CMD_REQUEST_FLIP, 8'd0, 8'd0, 0);
    issue_request(CMD_REQUEST_FLIP, 8'd0, 8'd0, 0);
    for (int i = 0; i < 16; i++) issue_request(CMD_SCAN_TICK, 8'd0, 8'd0, 0);

    // Random segments, each with the register setting and idle pattern planned for it.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      write_register(REG_GRAYSCALE, GRAY_PLAN[seg]);
      write_register(REG_DOUBLE_BUF, DBUF_PLAN[seg]);
      idle_pct = (seg < 2) ? 32 : (seg < 4) ? 80 : 0;
      flip_pct = $urandom_range(0, 3);
      for (int i = 0; i < SEGMENT_ITEMS; i++) random_request(flip_pct, idle_pct);
    end

    // Drain and report.
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
